/* rtl/assert_macros.svh */
// assertion macros shared by the rtl files
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MFCP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mfcp assertion failed");
`define MFCP_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("mfcp forbidden condition seen");
`else
`define MFCP_ASSERT(label, prop)
`define MFCP_ASSERT_NEVER(label, cond)
`endif
`endif

/* rtl/mfcp_pkg.sv */
// types, constants and crc helpers for the measurement frame parser
// no dependencies
package mfcp_pkg;

  localparam int unsigned FrameBytes = 18;
  localparam int unsigned PosW       = 5;
  localparam logic [7:0]  CrcPoly    = 8'h31;
  localparam logic [7:0]  CrcInit    = 8'hFF;
  localparam logic [7:0]  CrcTop     = 8'h80;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StCrc   = 2'd1,
    StShort = 2'd2
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [31:0] humidity_bits;
    logic [31:0] temperature_bits;
    logic [31:0] co2_bits;
  } result_t;

  // one byte through the msb-first crc-8 register
  function automatic logic [7:0] crc_feed(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if ((c & CrcTop) != 8'h00) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] crc_of_pair(logic [15:0] pair);
    return crc_feed(crc_feed(CrcInit, pair[15:8]), pair[7:0]);
  endfunction

endpackage

/* rtl/measurement_frame_crc_parser_unit.sv */
// Parses an 18-byte measurement reply (six triples of two data bytes and a
// crc-8 byte, poly 0x31, init 0xff) into three raw 32-bit words for co2,
// temperature and humidity, first byte most significant. One byte beat is
// taken every clock cycle; the result beat is written to the output register
// as the 18th byte is taken. Status is ok, crc error (words zero) or
// short frame (words zero) when frame_start arrives mid-frame. The input side
// stalls only while a result beat sits unread in the single output register.
// Depends on mfcp_pkg, mfcp_frame_core and assert_macros.svh.
`include "assert_macros.svh"

module measurement_frame_crc_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // [31:0] co2_bits, [63:32] temperature_bits,
                                      // [95:64] humidity_bits
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import mfcp_pkg::*;

  logic    s_accept;
  logic    core_valid;
  result_t core_res;
  logic    out_valid_q;
  result_t out_q;
  logic    status_known;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  mfcp_frame_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (s_accept),
    .rx_byte_i     (s_axis_tdata),
    .frame_start_i (s_axis_tuser[0]),
    .res_valid_o   (core_valid),
    .res_o         (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_accept && core_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept && core_valid) begin
      out_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.humidity_bits, out_q.temperature_bits, out_q.co2_bits};
  assign m_axis_tuser  = out_q.status;

  assign status_known = m_axis_tuser inside {StOk, StCrc, StShort};

  // error results never carry word data
  `MFCP_ASSERT(a_err_words_zero, m_axis_tvalid && (m_axis_tuser != StOk) |-> m_axis_tdata == '0)
  `MFCP_ASSERT_NEVER(a_status_code, m_axis_tvalid && !status_known)
  // a result produced on a taken byte lands in the output register
  `MFCP_ASSERT(a_result_loaded, s_accept && core_valid |=> m_axis_tvalid)

endmodule

/* rtl/mfcp_frame_core.sv */
// frame position tracking, word assembly and crc checks for one reply frame
// depends on mfcp_pkg
module mfcp_frame_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             frame_start_i,
  output logic             res_valid_o,
  output mfcp_pkg::result_t res_o
);
  import mfcp_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     pair_q, pair_d;
  logic [31:0]     co2_q, co2_d;
  logic [31:0]     temp_q, temp_d;
  logic [31:0]     hum_q, hum_d;
  logic            fail_q, fail_d;

  logic [PosW-1:0] pos_eff;
  logic [PosW-1:0] pos_w;
  logic [PosW-1:0] pos_n;
  logic            active;
  logic            is_crc;

  assign pos_eff = (pos_q >= PosW'(FrameBytes)) ? '0 : pos_q;
  assign is_crc  = pos_w inside {5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17};
  assign pos_n   = pos_w + PosW'(1);

  always_comb begin
    pos_d       = pos_q;
    pair_d      = pair_q;
    co2_d       = co2_q;
    temp_d      = temp_q;
    hum_d       = hum_q;
    fail_d      = fail_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    active      = 1'b1;
    pos_w       = pos_eff;

    if (frame_start_i) begin
      // restart drops any partial frame
      if (pos_eff != '0) begin
        res_valid_o  = 1'b1;
        res_o.status = StShort;
      end
      pair_d = '0;
      co2_d  = '0;
      temp_d = '0;
      hum_d  = '0;
      fail_d = 1'b0;
      pos_w  = '0;
    end else if (pos_eff == '0) begin
      active = 1'b0;
      pos_d  = '0;
    end

    if (active) begin
      if (!is_crc) begin
        pair_d = {pair_d[7:0], rx_byte_i};
        if (pos_w < PosW'(6)) begin
          co2_d = {co2_d[23:0], rx_byte_i};
        end else if (pos_w < PosW'(12)) begin
          temp_d = {temp_d[23:0], rx_byte_i};
        end else begin
          hum_d = {hum_d[23:0], rx_byte_i};
        end
      end else if (crc_of_pair(pair_d) != rx_byte_i) begin
        fail_d = 1'b1;
      end

      if (pos_n == PosW'(FrameBytes)) begin
        res_valid_o = 1'b1;
        if (fail_d) begin
          res_o.status = StCrc;
        end else begin
          res_o.status           = StOk;
          res_o.co2_bits         = co2_d;
          res_o.temperature_bits = temp_d;
          res_o.humidity_bits    = hum_d;
        end
        pos_d = '0;
      end else begin
        pos_d = pos_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      pair_q <= '0;
      co2_q  <= '0;
      temp_q <= '0;
      hum_q  <= '0;
      fail_q <= 1'b0;
    end else if (accept_i) begin
      pos_q  <= pos_d;
      pair_q <= pair_d;
      co2_q  <= co2_d;
      temp_q <= temp_d;
      hum_q  <= hum_d;
      fail_q <= fail_d;
    end
  end

endmodule
